[rtl/tbl_pkg.sv]
// Shared types, codes and constants of the token bucket byte limiter.
// No dependencies; every module of the block imports this package; the interfaces do not.
package tbl_pkg;

  localparam int TICK_W    = 48;
  localparam int BYTE_W    = 32;
  localparam int RATE_W    = 32;
  localparam int DATA_W    = 48;
  localparam int CFG_IDX_W = 3;

  // refill divides by ticks per second = 8 * 125: a shift, then base 2^16 digits
  localparam int TICKS_PER_SEC = 1000;
  localparam int DIV8_SHIFT    = 3;
  localparam int DIGIT_W       = 16;
  localparam int REM_W         = 7;
  localparam int STEP_W        = DIGIT_W + REM_W;

  // ceil(2^30 / 125): exact quotient for every 23-bit dividend
  localparam logic [23:0] RECIP_125   = 24'd8589935;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [6:0]  DIVISOR_125 = 7'd125;

  localparam logic [DATA_W-1:0] CAP_RESET = 48'd65536;

  typedef enum logic [1:0] {
    REQ_CHECK   = 2'd0,
    REQ_ACCOUNT = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_PASS  = 2'd0,
    ST_RATE  = 2'd1,
    ST_TOTAL = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE       = 3'd0,
    CFG_CAPACITY   = 3'd1,
    CFG_HARD_EN    = 3'd2,
    CFG_HARD_LIMIT = 3'd3,
    CFG_SOFT_EN    = 3'd4,
    CFG_SOFT_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [DATA_W-1:0] capacity;
    logic              hard_en;
    logic [DATA_W-1:0] hard_limit;
    logic              soft_en;
    logic [DATA_W-1:0] soft_limit;
  } tbl_cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TICK_W-1:0] now_tick;
    logic [BYTE_W-1:0] byte_count;
  } tbl_req_t;

  // what travels with a transaction down the refill pipeline
  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] byte_count;
    logic              tick_nz;
  } tbl_item_t;

  typedef struct packed {
    logic              allowed;
    status_t           status;
    logic              soft_crossed;
    logic [DATA_W-1:0] tokens_left;
  } tbl_rsp_t;

  // one long-division step by 125: returns {quotient digit, remainder}
  function automatic logic [STEP_W-1:0] div125_digit(input logic [REM_W-1:0] rem,
                                                      input logic [DIGIT_W-1:0] digit);
    logic [STEP_W-1:0]    v;
    logic [STEP_W+23:0]   prod;
    logic [DIGIT_W-1:0]   q;
    logic [STEP_W-1:0]    back;
    v    = {rem, digit};
    prod = (STEP_W+24)'(v) * (STEP_W+24)'(RECIP_125);
    q    = prod[RECIP_SHIFT +: DIGIT_W];
    back = STEP_W'(q) * STEP_W'(DIVISOR_125);
    return {q, REM_W'(v - back)};
  endfunction

endpackage

[rtl/tbl_if.sv]
// Valid/ready channel interfaces for the limiter's request and result streams.
// Field widths follow the limiter's request and result formats; no dependencies.
interface tbl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [47:0] now_tick;
  logic [31:0] byte_count;

  modport source (output valid, output req_type, output now_tick, output byte_count,
                  input ready);
  modport sink   (input valid, input req_type, input now_tick, input byte_count,
                  output ready);
endinterface

interface tbl_rsp_if;
  logic        valid;
  logic        ready;
  logic        allowed;
  logic [1:0]  status;
  logic        soft_crossed;
  logic [47:0] tokens_left;

  modport source (output valid, output allowed, output status, output soft_crossed,
                  output tokens_left, input ready);
  modport sink   (input valid, input allowed, input status, input soft_crossed,
                  input tokens_left, output ready);
endinterface

[rtl/tbl_refill.sv]
// Front of the refill pipeline: input register, last tick tracking, elapsed time,
// split rate x elapsed product and saturation check. Uses tbl_pkg.
module tbl_refill
  import tbl_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  tbl_req_t             req,
  input  logic [RATE_W-1:0]    rate,
  output logic                 x_valid,
  output tbl_item_t            x_item,
  output logic                 x_sat,
  output logic [DIGIT_W*((COUNT_WIDTH+REM_W+DIGIT_W-1)/DIGIT_W)-1:0] x_dividend
);

  localparam int W   = COUNT_WIDTH;
  localparam int HW  = (W + 1) / 2;
  localparam int LW  = W - HW;
  localparam int PW  = RATE_W + W;
  localparam int XW  = DIGIT_W * ((W + REM_W + DIGIT_W - 1) / DIGIT_W);
  localparam logic [PW:0] LIM_DIV = (PW+1)'(TICKS_PER_SEC) << W;
  localparam logic [PW:0] LIM_OVF = (PW+1)'(1) << 64;
  // from this value up the refill fills the bucket whatever the count
  localparam logic [PW:0] SAT_LIM = (LIM_DIV < LIM_OVF) ? LIM_DIV : LIM_OVF;

  logic                v0_r, v1_r, v2_r, v3_r;
  tbl_req_t            req0_r;
  logic [W-1:0]        last_tick_r;
  logic [W-1:0]        now_w;
  logic [W-1:0]        elapsed;
  logic [W-1:0]        e1_r;
  tbl_item_t           item1_r, item2_r, item3_r;
  logic [RATE_W+HW-1:0] pp_lo_r;
  logic [RATE_W+LW-1:0] pp_hi_r;
  logic [PW-1:0]       prod;
  logic                sat3_r;
  logic [XW-1:0]       x3_r;

  assign now_w   = W'(req0_r.now_tick);
  assign elapsed = now_w - last_tick_r;
  assign prod    = (PW'(pp_hi_r) << HW) + PW'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      last_tick_r <= '0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      // a check leaves last tick at now either way; restart sets it
      if (v0_r && (req0_r.req_type == REQ_CHECK || req0_r.req_type == REQ_RESTART)) begin
        last_tick_r <= now_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req0_r <= req;
    end
    e1_r    <= elapsed;
    item1_r <= '{req_type: req0_r.req_type, byte_count: req0_r.byte_count,
                 tick_nz: (elapsed != '0)};
    pp_lo_r <= (RATE_W+HW)'(rate) * (RATE_W+HW)'(e1_r[HW-1:0]);
    pp_hi_r <= (RATE_W+LW)'(rate) * (RATE_W+LW)'(e1_r[W-1:HW]);
    item2_r <= item1_r;
    sat3_r  <= {1'b0, prod} >= SAT_LIM;
    x3_r    <= XW'(prod >> DIV8_SHIFT);
    item3_r <= item2_r;
  end

  assign x_valid    = v3_r;
  assign x_item     = item3_r;
  assign x_sat      = sat3_r;
  assign x_dividend = x3_r;

endmodule

[rtl/tbl_div125.sv]
// Pipelined divide by 125, one base 2^16 digit per stage, most significant first.
// Carries the transaction alongside. Uses tbl_pkg (div125_digit).
module tbl_div125
  import tbl_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  tbl_item_t              in_item,
  input  logic                   in_sat,
  input  logic [DIGIT_W*((COUNT_WIDTH+REM_W+DIGIT_W-1)/DIGIT_W)-1:0] in_dividend,
  output logic                   out_valid,
  output tbl_item_t              out_item,
  output logic                   out_sat,
  output logic [COUNT_WIDTH-1:0] out_quot
);

  localparam int W  = COUNT_WIDTH;
  localparam int ND = (W + REM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int XW = DIGIT_W * ND;

  logic              v_r    [ND];
  tbl_item_t         item_r [ND];
  logic              sat_r  [ND];
  logic [XW-1:0]     q_r    [ND];
  logic [XW-1:0]     x_r    [ND-1];
  logic [REM_W-1:0]  rem_r  [ND-1];

  for (genvar k = 0; k < ND; k++) begin : g_digit
    logic              pv;
    tbl_item_t         pitem;
    logic              psat;
    logic [XW-1:0]     px;
    logic [XW-1:0]     pq;
    logic [REM_W-1:0]  prem;
    logic [STEP_W-1:0] step;
    logic [XW-1:0]     q_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign pitem = in_item;
      assign psat  = in_sat;
      assign px    = in_dividend;
      assign pq    = '0;
      assign prem  = '0;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign pitem = item_r[k-1];
      assign psat  = sat_r[k-1];
      assign px    = x_r[k-1];
      assign pq    = q_r[k-1];
      assign prem  = rem_r[k-1];
    end

    assign step = div125_digit(prem, px[(ND-1-k)*DIGIT_W +: DIGIT_W]);

    always_comb begin
      q_nxt = pq;
      q_nxt[(ND-1-k)*DIGIT_W +: DIGIT_W] = step[STEP_W-1:REM_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      item_r[k] <= pitem;
      sat_r[k]  <= psat;
      q_r[k]    <= q_nxt;
    end

    if (k < ND - 1) begin : g_carry
      always_ff @(posedge clk) begin
        x_r[k]   <= px;
        rem_r[k] <= step[REM_W-1:0];
      end
    end
  end

  assign out_valid = v_r[ND-1];
  assign out_item  = item_r[ND-1];
  assign out_sat   = sat_r[ND-1];
  assign out_quot  = q_r[ND-1][W-1:0];

endmodule

[rtl/tbl_bucket.sv]
// Token count, usage total and soft warning flag; forms the result of each transaction.
// Uses tbl_pkg; fed with the refill amount from tbl_div125.
module tbl_bucket
  import tbl_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  tbl_item_t              in_item,
  input  logic                   in_sat,
  input  logic [COUNT_WIDTH-1:0] in_add,
  input  tbl_cfg_t               cfg,
  output logic                   out_valid,
  output tbl_rsp_t               out_rsp
);

  localparam int W  = COUNT_WIDTH;
  localparam int LW = ((W > DATA_W) ? W : DATA_W) + 1;

  logic [W-1:0]  tok_r, tok_nxt;
  logic [W-1:0]  used_r, used_nxt;
  logic          soft_warned_r, soft_warned_nxt;
  logic [W-1:0]  cap_w;
  logic [W-1:0]  bytes_w;
  logic [W:0]    tok_sum;
  logic [W-1:0]  refill;
  logic [W-1:0]  avail;
  logic          hard_fail;
  logic [W:0]    used_sum;
  logic [W-1:0]  used_acc;
  tbl_rsp_t      rsp;

  assign cap_w   = W'(cfg.capacity);
  assign bytes_w = W'(in_item.byte_count);
  assign tok_sum = (W+1)'(tok_r) + (W+1)'(in_add);
  assign refill  = (in_sat || tok_r >= cap_w || tok_sum >= (W+1)'(cap_w)) ? cap_w
                                                                        : tok_sum[W-1:0];
  assign avail   = in_item.tick_nz ? refill : tok_r;

  // used + bytes > limit covers bytes > limit as well
  assign hard_fail = cfg.hard_en &&
                     ((LW'(used_r) + LW'(in_item.byte_count)) > LW'(cfg.hard_limit));

  assign used_sum = (W+1)'(used_r) + (W+1)'(in_item.byte_count);
  assign used_acc = used_sum[W] ? '1 : used_sum[W-1:0];

  always_comb begin
    tok_nxt          = tok_r;
    used_nxt         = used_r;
    soft_warned_nxt  = soft_warned_r;
    rsp.allowed      = 1'b0;
    rsp.status       = ST_DONE;
    rsp.soft_crossed = 1'b0;
    if (in_valid) begin
      unique case (in_item.req_type)
        REQ_CHECK: begin
          if (avail >= bytes_w) begin
            tok_nxt = avail - bytes_w;
            if (hard_fail) begin
              rsp.status = ST_TOTAL;
            end else begin
              rsp.status  = ST_PASS;
              rsp.allowed = 1'b1;
            end
          end else begin
            tok_nxt    = avail;
            rsp.status = ST_RATE;
          end
        end
        REQ_ACCOUNT: begin
          used_nxt = used_acc;
          if (cfg.soft_en && !soft_warned_r && (LW'(used_acc) > LW'(cfg.soft_limit))) begin
            soft_warned_nxt  = 1'b1;
            rsp.soft_crossed = 1'b1;
          end
        end
        REQ_RESTART: begin
          tok_nxt = cap_w;
        end
        default: ;
      endcase
    end
    rsp.tokens_left = DATA_W'(tok_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r         <= W'(CAP_RESET);
      used_r        <= '0;
      soft_warned_r <= 1'b0;
    end else begin
      tok_r         <= tok_nxt;
      used_r        <= used_nxt;
      soft_warned_r <= soft_warned_nxt;
    end
  end

  assign out_valid = in_valid;
  assign out_rsp   = rsp;

  a_warn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    soft_warned_r |=> soft_warned_r)
    else $error("soft warning flag cleared");

  a_refill_capped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_item.req_type == REQ_CHECK && in_item.tick_nz |=> tok_r <= cap_w)
    else $error("token count above capacity after refill");

  a_cross_account: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && rsp.soft_crossed |-> cfg.soft_en && in_item.req_type == REQ_ACCOUNT)
    else $error("soft crossing flagged outside an account transaction");

endmodule

[rtl/token_bucket_byte_limiter_unit.sv]
// Token bucket byte limiter: check, account and restart requests, one result each.
// Path from accept to result: refill input, elapsed, product and saturation registers,
// then the digit-per-stage divide by 1000, then the result FIFO.
// Throughput: one transaction per cycle; a result FIFO of ND+6 entries (10 at 48) with one
// credit per transaction in flight; input ready drops only once all credits are held.
// Reset (synchronous, rst_n low): registers to defaults, tokens 65536, pipeline empty.
module token_bucket_byte_limiter_unit
  import tbl_pkg::*;
#(
  parameter int COUNT_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  tbl_req_if.sink              in_ch,
  tbl_rsp_if.source            out_ch
);

  localparam int W     = COUNT_WIDTH;
  localparam int ND    = (W + REM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int XW    = DIGIT_W * ND;
  localparam int DEPTH = ND + 6;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  tbl_cfg_t       cfg_r;
  tbl_req_t       req;
  logic           acc;
  logic           take;
  logic [CW-1:0]  cred_r;
  logic [CW-1:0]  occ_r;
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  tbl_rsp_t       fifo_r [DEPTH];
  tbl_rsp_t       head;

  logic           x_valid;
  tbl_item_t      x_item;
  logic           x_sat;
  logic [XW-1:0]  x_dividend;
  logic           q_valid;
  tbl_item_t      q_item;
  logic           q_sat;
  logic [W-1:0]   q_add;
  logic           rsp_valid;
  tbl_rsp_t       rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rate: '0, capacity: CAP_RESET, hard_en: 1'b0, hard_limit: '0,
                 soft_en: 1'b0, soft_limit: '0};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RATE:       cfg_r.rate       <= cfg_wdata[RATE_W-1:0];
        CFG_CAPACITY:   cfg_r.capacity   <= cfg_wdata;
        CFG_HARD_EN:    cfg_r.hard_en    <= cfg_wdata[0];
        CFG_HARD_LIMIT: cfg_r.hard_limit <= cfg_wdata;
        CFG_SOFT_EN:    cfg_r.soft_en    <= cfg_wdata[0];
        CFG_SOFT_LIMIT: cfg_r.soft_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // credits count transactions accepted and not yet delivered
  assign in_ch.ready = cred_r < CW'(DEPTH);
  assign acc         = in_ch.valid && in_ch.ready;
  assign take        = out_ch.valid && out_ch.ready;
  assign req         = '{req_type: in_ch.req_type, now_tick: in_ch.now_tick,
                         byte_count: in_ch.byte_count};

  tbl_refill #(.COUNT_WIDTH(W)) u_refill (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .req        (req),
    .rate       (cfg_r.rate),
    .x_valid    (x_valid),
    .x_item     (x_item),
    .x_sat      (x_sat),
    .x_dividend (x_dividend)
  );

  tbl_div125 #(.COUNT_WIDTH(W)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (x_valid),
    .in_item     (x_item),
    .in_sat      (x_sat),
    .in_dividend (x_dividend),
    .out_valid   (q_valid),
    .out_item    (q_item),
    .out_sat     (q_sat),
    .out_quot    (q_add)
  );

  tbl_bucket #(.COUNT_WIDTH(W)) u_bucket (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_sat    (q_sat),
    .in_add    (q_add),
    .cfg       (cfg_r),
    .out_valid (rsp_valid),
    .out_rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r   <= '0;
      occ_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cred_r <= cred_r + CW'(acc) - CW'(take);
      occ_r  <= occ_r + CW'(rsp_valid) - CW'(take);
      if (rsp_valid) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      fifo_r[wr_ptr_r] <= rsp;
    end
  end

  assign head                = fifo_r[rd_ptr_r];
  assign out_ch.valid        = occ_r != '0;
  assign out_ch.allowed      = head.allowed;
  assign out_ch.status       = head.status;
  assign out_ch.soft_crossed = head.soft_crossed;
  assign out_ch.tokens_left  = head.tokens_left;

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid && !take |-> occ_r < CW'(DEPTH))
    else $error("result FIFO overflow");

  a_occ_le_cred: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cred_r)
    else $error("more buffered results than transactions in flight");

  a_cred_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> cred_r != '0)
    else $error("credit count lost an accepted transaction");

endmodule
